FILE: src/exchange_selection_sorter_core_macros.svh
// ----------------------------------------------------------------------------
// Exchange selection sorter - assertion macros
// Shared property wrappers for the sorter's checker.
// ----------------------------------------------------------------------------
`ifndef EXCHANGE_SELECTION_SORTER_CORE_MACROS_SVH
`define EXCHANGE_SELECTION_SORTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ESC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ESC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/esc_pkg.sv
// ----------------------------------------------------------------------------
// Exchange selection sorter - package
// Element type shared by the core, its store and its checker.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_value;

endpackage

FILE: src/esc_mem.sv
// ----------------------------------------------------------------------------
// Exchange selection sorter - element store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module esc_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  esc_pkg::t_value i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output esc_pkg::t_value o_rdata
);
    import esc_pkg::*;

    t_value r_mem [DEPTH];
    t_value r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/exchange_selection_sorter_core.sv
// ----------------------------------------------------------------------------
// Exchange selection sorter - top level
// Collects signed elements, sorts them ascending by exchange selection sort
// in a single-port-read store and streams the sorted set out.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_value_in, i_last_in
//  out     | output    | o_out_valid/i_out_ready | o_value_out, o_last_out,
//          |           |                         | o_overflow
//
//  Loading accepts one item per cycle. After the item marked last, the sort
//  is bound by the one read port of the store: each pass reads a[i], then
//  reads and compares a[n-1] down to a[i+1], then writes back the minimum.
//  Emitting reads each result, then loads it into the output register;
//  a stalled consumer holds the output register.
//  Reset (synchronous, active low) empties the set and clears the output
//  valid; the store itself is not cleared, only entries of the current set
//  are ever read.
//  The next set may start loading while the final result still waits.
// ----------------------------------------------------------------------------
module exchange_selection_sorter_core #(
    parameter int CAPACITY = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  esc_pkg::t_value i_value_in,
    input  logic            i_last_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output esc_pkg::t_value o_value_out,
    output logic            o_last_out,
    output logic            o_overflow
);
    import esc_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Sequencer states
    localparam logic [2:0] S_LOAD  = 3'd0; // collect items
    localparam logic [2:0] S_RDI   = 3'd1; // read a[i]
    localparam logic [2:0] S_RDJ0  = 3'd2; // latch a[i], read a[n-1]
    localparam logic [2:0] S_SCAN  = 3'd3; // compare a[j] with a[i], swap
    localparam logic [2:0] S_WBI   = 3'd4; // write back the pass minimum
    localparam logic [2:0] S_EREAD = 3'd5; // read a[k] for output
    localparam logic [2:0] S_EOUT  = 3'd6; // move a[k] to output register

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_dropped, n_dropped;
    logic [AW-1:0] r_i, n_i;    // position being filled
    logic [AW-1:0] r_j, n_j;    // next index to read during a pass
    logic [AW-1:0] r_cj, n_cj;  // index whose data is on the read port
    logic [AW-1:0] r_k, n_k;    // emit index
    t_value        r_ai, n_ai;  // running a[i]

    logic          r_out_valid, n_out_valid;
    t_value        r_out_value, n_out_value;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_value        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_value        mem_rdata;

    logic [CW-1:0] cnt_new;
    logic          emit_last;

    esc_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready = (r_state == S_LOAD);
    assign emit_last  = ((CW'(r_k) + CW'(1)) == r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_i         = r_i;
        n_j         = r_j;
        n_cj        = r_cj;
        n_k         = r_k;
        n_ai        = r_ai;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        mem_we      = 1'b0;
        mem_waddr   = r_cj;
        mem_wdata   = r_ai;
        mem_re      = 1'b0;
        mem_raddr   = r_i;
        cnt_new     = r_count;

        // Drop the output item once it is taken; a reload below overrides.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (r_count < CW'(CAPACITY)) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[AW-1:0];
                        mem_wdata = i_value_in;
                        cnt_new   = r_count + CW'(1);
                    end else begin
                        // Store full: drop the item, remember it.
                        n_dropped = 1'b1;
                    end
                    n_count = cnt_new;
                    if (i_last_in) begin
                        n_i = '0;
                        n_k = '0;
                        // A single element needs no sorting.
                        n_state = (cnt_new < CW'(2)) ? S_EREAD : S_RDI;
                    end
                end
            end
            S_RDI: begin
                mem_re    = 1'b1;
                mem_raddr = r_i;
                n_j       = AW'(r_count - CW'(1));
                n_state   = S_RDJ0;
            end
            S_RDJ0: begin
                mem_re    = 1'b1;
                mem_raddr = r_j;
                n_ai      = mem_rdata;
                n_cj      = r_j;
                n_j       = r_j - AW'(1);
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                // Swap: a[j] takes the old a[i], a[i] is carried in a register.
                if (mem_rdata < r_ai) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cj;
                    mem_wdata = r_ai;
                    n_ai      = mem_rdata;
                end
                if (r_cj != (r_i + AW'(1))) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_j;
                    n_cj      = r_j;
                    n_j       = r_j - AW'(1);
                end else begin
                    n_state = S_WBI;
                end
            end
            S_WBI: begin
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = r_ai;
                n_i       = r_i + AW'(1);
                if ((CW'(r_i) + CW'(2)) < r_count) begin
                    n_state = S_RDI;
                end else begin
                    n_k     = '0;
                    n_state = S_EREAD;
                end
            end
            S_EREAD: begin
                mem_re    = 1'b1;
                mem_raddr = r_k;
                n_state   = S_EOUT;
            end
            S_EOUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = mem_rdata;
                    n_out_last  = emit_last;
                    n_out_ovf   = r_dropped;
                    n_k         = r_k + AW'(1);
                    if (emit_last) begin
                        // Set done: empty the set for the next one.
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_state   = S_LOAD;
                    end else begin
                        n_state = S_EREAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_j         <= n_j;
        r_cj        <= n_cj;
        r_k         <= n_k;
        r_ai        <= n_ai;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out_valid = r_out_valid;
    assign o_value_out = r_out_value;
    assign o_last_out  = r_out_last;
    assign o_overflow  = r_out_ovf;

endmodule

FILE: src/esc_chk.sv
// ----------------------------------------------------------------------------
// Exchange selection sorter - port checker
// Watches the top-level ports and flags sequencing slips.
// ----------------------------------------------------------------------------
`include "exchange_selection_sorter_core_macros.svh"

module esc_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input esc_pkg::t_value i_value_in,
    input logic            i_last_in,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input esc_pkg::t_value o_value_out,
    input logic            o_last_out,
    input logic            o_overflow
);

    // A stalled output item holds.
    `ESC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_value_out) && $stable(o_last_out) && $stable(o_overflow), "output item changed while stalled")

    // The item marked last closes the input until the set is out.
    `ESC_ASSERT_NXT(a_last_closes, i_clk, i_rst_n, i_in_valid && o_in_ready && i_last_in, !o_in_ready, "input still open after last item")

    // While a non-final result waits, the run is still emitting.
    `ESC_ASSERT_IMP(a_mid_run_closed, i_clk, i_rst_n, o_out_valid && !o_last_out, !o_in_ready, "input open in the middle of a run")

    // The overflow mark is the same on every result of one run.
    `ESC_ASSERT_NXT(a_ovf_steady, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last_out, !o_out_valid || (o_overflow == $past(o_overflow)), "overflow mark changed within a run")

endmodule

bind exchange_selection_sorter_core esc_chk u_esc_chk (.*);
